FILE: rtl/core/fdh_pkg.sv
// Shared constants and controller/datapath handshake types for the density histogram.
package fdh_pkg;

    // Grid and component geometry.
    localparam int GRID_X     = 32;
    localparam int GRID_Y     = 32;
    localparam int GRID_Z     = 32;
    localparam int COMPONENTS = 8;

    localparam int XW      = $clog2(GRID_X);
    localparam int YW      = $clog2(GRID_Y);
    localparam int ZW      = $clog2(GRID_Z);
    localparam int CMP_IW  = $clog2(COMPONENTS);
    localparam int BIN_W   = 5;
    localparam int XRW     = (XW > BIN_W) ? XW : BIN_W;
    localparam int YRW     = (YW > BIN_W) ? YW : BIN_W;
    localparam int ZRW     = (ZW > BIN_W) ? ZW : BIN_W;

    // Histogram store.
    localparam int DEPTH   = COMPONENTS * GRID_X * GRID_Y * GRID_Z;
    localparam int AW      = $clog2(DEPTH);

    // Fixed-point widths.
    localparam int FRAC_W     = 48;
    localparam int GRID_MUL_W = 9;
    localparam int BP_W       = FRAC_W + GRID_MUL_W;
    localparam int CNT_W      = 32;

    // Multiplier sequence: six products, then a final step that adds the last one.
    localparam int MUL_STEPS = 6;
    localparam int STEP_W    = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_XZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_YZ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ZZ = 3'd5;

    // Item actions.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic [STEP_W-1:0] step;
        logic              bin;
        logic              rd;
        logic              upd;
        logic              clr;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/fdh_in_if.sv
// Input item channel: valid/ready handshake with the sample or read payload.
interface fdh_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [2:0]  component;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [4:0]  read_x;
    logic [4:0]  read_y;
    logic [4:0]  read_z;

    modport source (
        output valid, action, component, pos_x, pos_y, pos_z, read_x, read_y, read_z,
        input  ready
    );
    modport sink (
        input  valid, action, component, pos_x, pos_y, pos_z, read_x, read_y, read_z,
        output ready
    );
endinterface

FILE: rtl/core/fdh_out_if.sv
// Result channel: valid/ready handshake with the bin and count payload.
interface fdh_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  bin_x;
    logic [4:0]  bin_y;
    logic [4:0]  bin_z;
    logic [31:0] bin_count;
    logic [31:0] component_max;

    modport source (
        output valid, bin_x, bin_y, bin_z, bin_count, component_max,
        input  ready
    );
    modport sink (
        input  valid, bin_x, bin_y, bin_z, bin_count, component_max,
        output ready
    );
endinterface

FILE: rtl/core/fractional_density_histogram.sv
// Top level of the per-component fractional-coordinate density histogram.
//
// Channels: i_in carries one item per transfer. A sample item (action 0)
// gives a component and a Q16.16 position; the position is mapped through
// the upper-triangular inverse cell matrix, wrapped into the unit cell,
// binned, and that bin's count is incremented with saturation. A read item
// (action 1) returns the count of a given bin without changing anything.
// Every item yields exactly one transfer on o_out, in order.
// The six inverse cell entries are written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata; the user must write them only while the block is idle and
// the block does not enforce this. A write takes effect at once. The block
// works on one item at a time. Samples are paced by the six products
// sharing one 32x32 multiplier and by the read-modify-write of the
// histogram memory; a read item skips the multiply steps. The result
// appears on o_out in the cycle after the item completes.
// Reset: the inverse entries and maxima go to zero and the histogram memory
// is swept to zero at one entry per cycle over all 262144 entries, during
// which i_in.ready stays low. A stalled receiver holds the result in the
// output register; the block still takes the next item and stops only when
// a new result is ready while the previous one has not been taken.
module fractional_density_histogram import fdh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    fdh_in_if.sink               i_in,
    fdh_out_if.source            o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // The controller owns the input handshake and issues one command per cycle.
    fdh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    assign i_in.ready = w_in_ready;

    // The datapath holds all payload, the memory and the output register.
    fdh_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_in.action),
        .i_component     (i_in.component),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_pos_z         (i_in.pos_z),
        .i_read_x        (i_in.read_x),
        .i_read_y        (i_in.read_y),
        .i_read_z        (i_in.read_z),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_bin_x         (o_out.bin_x),
        .o_bin_y         (o_out.bin_y),
        .o_bin_z         (o_out.bin_z),
        .o_bin_count     (o_out.bin_count),
        .o_component_max (o_out.component_max),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts)
    );

endmodule

FILE: rtl/core/fdh_datapath.sv
// Datapath: inverse-cell registers, shared multiplier, binning, histogram memory, result register.
module fdh_datapath import fdh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_action,
    input  logic [2:0]           i_component,
    input  logic [31:0]          i_pos_x,
    input  logic [31:0]          i_pos_y,
    input  logic [31:0]          i_pos_z,
    input  logic [4:0]           i_read_x,
    input  logic [4:0]           i_read_y,
    input  logic [4:0]           i_read_z,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [BIN_W-1:0]     o_bin_x,
    output logic [BIN_W-1:0]     o_bin_y,
    output logic [BIN_W-1:0]     o_bin_z,
    output logic [CNT_W-1:0]     o_bin_count,
    output logic [CNT_W-1:0]     o_component_max,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts
);

    logic signed [31:0] r_inv_xx, r_inv_xy, r_inv_xz, r_inv_yy, r_inv_yz, r_inv_zz;
    logic               r_action;
    logic [2:0]         r_comp;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic [XRW-1:0]     r_bx;
    logic [YRW-1:0]     r_by;
    logic [ZRW-1:0]     r_bz;
    logic               r_idx_ok;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_clr_addr;
    logic [FRAC_W-1:0]  r_prod;
    logic [FRAC_W-1:0]  r_acc_x, r_acc_y, r_acc_z;
    logic [CNT_W-1:0]   r_rdata;
    logic [CNT_W-1:0]   r_max [COMPONENTS];
    logic               r_out_valid;
    logic [BIN_W-1:0]   r_out_bx, r_out_by, r_out_bz;
    logic [CNT_W-1:0]   r_out_count, r_out_max;

    logic [CNT_W-1:0]   mem [DEPTH];

    logic signed [31:0] w_op_a, w_op_b;
    logic signed [63:0] w_mul;
    logic [BP_W-1:0]    w_px, w_py, w_pz;
    logic [XRW-1:0]     n_bx;
    logic [YRW-1:0]     n_by;
    logic [ZRW-1:0]     n_bz;
    logic [AW-1:0]      n_addr;
    logic               w_comp_ok;
    logic [CNT_W-1:0]   w_new, w_old_max, w_new_max;
    logic [CNT_W-1:0]   n_count, n_max;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_xx <= '0;
            r_inv_xy <= '0;
            r_inv_xz <= '0;
            r_inv_yy <= '0;
            r_inv_yz <= '0;
            r_inv_zz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_XX: r_inv_xx <= i_cfg_wdata;
                CFG_INV_XY: r_inv_xy <= i_cfg_wdata;
                CFG_INV_XZ: r_inv_xz <= i_cfg_wdata;
                CFG_INV_YY: r_inv_yy <= i_cfg_wdata;
                CFG_INV_YZ: r_inv_yz <= i_cfg_wdata;
                CFG_INV_ZZ: r_inv_zz <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.step)
            3'd0:    begin w_op_a = r_inv_xx; w_op_b = r_pos_x; end
            3'd1:    begin w_op_a = r_inv_xy; w_op_b = r_pos_y; end
            3'd2:    begin w_op_a = r_inv_xz; w_op_b = r_pos_z; end
            3'd3:    begin w_op_a = r_inv_yy; w_op_b = r_pos_y; end
            3'd4:    begin w_op_a = r_inv_yz; w_op_b = r_pos_z; end
            3'd5:    begin w_op_a = r_inv_zz; w_op_b = r_pos_z; end
            default: begin w_op_a = '0;       w_op_b = '0;       end
        endcase
    end

    assign w_mul = w_op_a * w_op_b;

    // Only the low 48 bits of each sum survive, which is the wrapped fraction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_mul[FRAC_W-1:0];
            case (i_cmd.step)
                3'd0: begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_acc_z <= '0;
                end
                3'd1, 3'd2, 3'd3: r_acc_x <= r_acc_x + r_prod;
                3'd4, 3'd5:       r_acc_y <= r_acc_y + r_prod;
                default:          r_acc_z <= r_acc_z + r_prod;
            endcase
        end
    end

    // Bin = floor(fraction * grid).
    assign w_px = {GRID_MUL_W'(0), r_acc_x} * BP_W'(GRID_X);
    assign w_py = {GRID_MUL_W'(0), r_acc_y} * BP_W'(GRID_Y);
    assign w_pz = {GRID_MUL_W'(0), r_acc_z} * BP_W'(GRID_Z);

    assign n_bx = (r_action == ACT_READ) ? r_bx : XRW'(w_px[FRAC_W +: XW]);
    assign n_by = (r_action == ACT_READ) ? r_by : YRW'(w_py[FRAC_W +: YW]);
    assign n_bz = (r_action == ACT_READ) ? r_bz : ZRW'(w_pz[FRAC_W +: ZW]);

    assign n_addr = ((AW'(r_comp) * AW'(GRID_X) + AW'(n_bx)) * AW'(GRID_Y) + AW'(n_by))
                    * AW'(GRID_Z) + AW'(n_bz);

    assign w_comp_ok = 32'(r_comp) < COMPONENTS;

    // Item capture and bin/address registration.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_comp   <= i_component;
            r_pos_x  <= i_pos_x;
            r_pos_y  <= i_pos_y;
            r_pos_z  <= i_pos_z;
            r_bx     <= XRW'(i_read_x);
            r_by     <= YRW'(i_read_y);
            r_bz     <= ZRW'(i_read_z);
        end else if (i_cmd.bin) begin
            r_bx     <= n_bx;
            r_by     <= n_by;
            r_bz     <= n_bz;
            r_addr   <= n_addr;
            r_idx_ok <= (r_action != ACT_READ) ||
                        ((32'(r_bx) < GRID_X) && (32'(r_by) < GRID_Y) && (32'(r_bz) < GRID_Z));
        end
    end

    // Read-modify-write arithmetic.
    assign w_old_max = r_max[r_comp[CMP_IW-1:0]];
    assign w_new     = (r_rdata == '1) ? r_rdata : r_rdata + CNT_W'(1);
    assign w_new_max = (w_new > w_old_max) ? w_new : w_old_max;

    always_comb begin
        if (!w_comp_ok) begin
            n_count = '0;
            n_max   = '0;
        end else if (r_action == ACT_READ) begin
            n_count = r_idx_ok ? r_rdata : '0;
            n_max   = w_old_max;
        end else begin
            n_count = w_new;
            n_max   = w_new_max;
        end
    end

    // Histogram memory with the post-reset clearing sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.upd && w_comp_ok && (r_action == ACT_SAMPLE)) begin
            mem[r_addr] <= w_new;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COMPONENTS; i++) begin
                r_max[i] <= '0;
            end
        end else if (i_cmd.upd && w_comp_ok && (r_action == ACT_SAMPLE)) begin
            r_max[r_comp[CMP_IW-1:0]] <= w_new_max;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_bx    <= r_bx[BIN_W-1:0];
            r_out_by    <= r_by[BIN_W-1:0];
            r_out_bz    <= r_bz[BIN_W-1:0];
            r_out_count <= n_count;
            r_out_max   <= n_max;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bin_x         = r_out_bx;
    assign o_bin_y         = r_out_by;
    assign o_bin_z         = r_out_bz;
    assign o_bin_count     = r_out_count;
    assign o_component_max = r_out_max;

    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

FILE: rtl/core/fdh_ctrl.sv
// Controller: sequences clearing, multiply steps, binning and the memory read-modify-write.
module fdh_ctrl import fdh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_action,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_BIN   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = (i_in_action == ACT_READ) ? S_BIN : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS)) begin
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                o_cmd.bin = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/fdh_checker.sv
// Port-level checker for the density histogram, bound to the top level.
module fdh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_bin_x,
    input logic [31:0] i_bin_count,
    input logic [31:0] i_component_max
);

    // A held result must not change under the receiver's stall.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_bin_count) && $stable(i_bin_x))
        else $error("result changed while stalled");

    // Items are worked one at a time, so ready drops after every input transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in progress");

    // The running maximum of a component bounds every bin count it reports.
    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bin_count <= i_component_max)
        else $error("bin count above component maximum");

    // Reset starts the clearing sweep, during which no input is taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during clearing sweep");

endmodule

bind fractional_density_histogram fdh_checker u_fdh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_bin_x         (o_out.bin_x),
    .i_bin_count     (o_out.bin_count),
    .i_component_max (o_out.component_max)
);

FILE: tb/tb.sv
// Self-checking testbench for the fractional-coordinate density histogram.
`timescale 1ns / 1ps

module tb;
    import fdh_pkg::*;

    // Index codes past the six inverse entries; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;

    // One input item as it goes over the input channel.
    typedef struct {
        logic              action;
        logic [2:0]        component;
        logic [31:0]       pos_x;
        logic [31:0]       pos_y;
        logic [31:0]       pos_z;
        logic [4:0]        read_x;
        logic [4:0]        read_y;
        logic [4:0]        read_z;
    } t_hist_op;

    // One result item: the bin that was touched or read and its counts.
    typedef struct {
        logic [4:0]  bin_x;
        logic [4:0]  bin_y;
        logic [4:0]  bin_z;
        logic [31:0] bin_count;
        logic [31:0] component_max;
    } t_bin_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_wdata;

    fdh_in_if  in_ch ();
    fdh_out_if out_ch ();

    fractional_density_histogram dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local picture of the block: the inverse cell entries as last written,
    // the bin counts that have been touched (absent means zero), and the
    // running maximum of each component.
    logic [31:0]       inv_cell [6];
    logic [31:0]       bin_counts [int unsigned];
    logic [31:0]       peak_count [COMPONENTS];

    t_hist_op          op_queue [$];
    t_bin_report       due_reports [$];
    t_hist_op          on_bus;
    logic [31:0]       hot_pos [6][3];

    int unsigned       gap_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       hold_left = 0;
    int unsigned       hold_req = 0;
    int unsigned       hold_seen = 0;
    logic              idle_on = 1'b0;
    logic              stall_on = 1'b0;
    int unsigned       fault_count = 0;

    // Exact 32x32 signed product, sign-extended to 64 bits.
    function automatic longint signed_product(input logic [31:0] a, input logic [31:0] b);
        return longint'($signed(a)) * longint'($signed(b));
    endfunction

    // Keep the low 48 bits as the wrapped fraction and scale it onto the grid.
    function automatic int unsigned frac_to_bin(input longint acc, input int unsigned grid);
        logic [63:0] scaled;
        scaled = {16'd0, acc[47:0]} * 64'(grid);
        return int'(scaled[63:48]);
    endfunction

    // Bin coordinates of a sample position under the current inverse cell.
    // The matrix is upper-triangular, so y ignores x and z ignores both.
    function automatic void locate_bin(input t_hist_op op, output int unsigned bx,
                                       output int unsigned by, output int unsigned bz);
        longint sx;
        longint sy;
        longint sz;
        sx = signed_product(inv_cell[CFG_INV_XX], op.pos_x)
           + signed_product(inv_cell[CFG_INV_XY], op.pos_y)
           + signed_product(inv_cell[CFG_INV_XZ], op.pos_z);
        sy = signed_product(inv_cell[CFG_INV_YY], op.pos_y)
           + signed_product(inv_cell[CFG_INV_YZ], op.pos_z);
        sz = signed_product(inv_cell[CFG_INV_ZZ], op.pos_z);
        bx = frac_to_bin(sx, GRID_X);
        by = frac_to_bin(sy, GRID_Y);
        bz = frac_to_bin(sz, GRID_Z);
    endfunction

    // Apply one item to the local histogram and return the report it yields.
    function automatic t_bin_report histogram_step(input t_hist_op op);
        t_bin_report rep;
        int unsigned bx;
        int unsigned by;
        int unsigned bz;
        int unsigned slot;
        logic [31:0] cnt;
        bit          comp_ok;
        rep = '{default: '0};
        comp_ok = op.component < COMPONENTS;
        if (op.action == ACT_SAMPLE) begin
            locate_bin(op, bx, by, bz);
            if (comp_ok) begin
                slot = ((op.component * GRID_X + bx) * GRID_Y + by) * GRID_Z + bz;
                cnt = bin_counts.exists(slot) ? bin_counts[slot] : 32'd0;
                // The count saturates at all ones.
                if (cnt != 32'hFFFF_FFFF) cnt = cnt + 32'd1;
                bin_counts[slot] = cnt;
                if (cnt > peak_count[op.component]) peak_count[op.component] = cnt;
                rep.bin_count     = cnt;
                rep.component_max = peak_count[op.component];
            end
        end else begin
            bx = op.read_x;
            by = op.read_y;
            bz = op.read_z;
            if (comp_ok) begin
                rep.component_max = peak_count[op.component];
                // A read outside the grid reports a zero count.
                if (bx < GRID_X && by < GRID_Y && bz < GRID_Z) begin
                    slot = ((op.component * GRID_X + bx) * GRID_Y + by) * GRID_Z + bz;
                    if (bin_counts.exists(slot)) rep.bin_count = bin_counts[slot];
                end
            end
        end
        rep.bin_x = bx[4:0];
        rep.bin_y = by[4:0];
        rep.bin_z = bz[4:0];
        return rep;
    endfunction

    // Fields that the action does not use are filled with random bits.
    function automatic t_hist_op sample_op(input logic [2:0] comp, input logic [31:0] px,
                                           input logic [31:0] py, input logic [31:0] pz);
        t_hist_op op;
        op.action    = ACT_SAMPLE;
        op.component = comp;
        op.pos_x     = px;
        op.pos_y     = py;
        op.pos_z     = pz;
        op.read_x    = 5'($urandom);
        op.read_y    = 5'($urandom);
        op.read_z    = 5'($urandom);
        return op;
    endfunction

    function automatic t_hist_op read_op(input logic [2:0] comp, input logic [4:0] rx,
                                         input logic [4:0] ry, input logic [4:0] rz);
        t_hist_op op;
        op.action    = ACT_READ;
        op.component = comp;
        op.pos_x     = $urandom;
        op.pos_y     = $urandom;
        op.pos_z     = $urandom;
        op.read_x    = rx;
        op.read_y    = ry;
        op.read_z    = rz;
        return op;
    endfunction

    function automatic logic [31:0] near_cell(input int unsigned span);
        return 32'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    // Random item. Samples mostly land near the cell, and a good share hit
    // a few hot positions on two components so that counts and maxima grow.
    // Half of the reads look at a hot bin, the rest anywhere in the grid.
    function automatic t_hist_op random_op(input int unsigned span);
        t_hist_op    op;
        int unsigned pick;
        int unsigned bx;
        int unsigned by;
        int unsigned bz;
        pick = $urandom_range(0, 5);
        if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 1) == 0) begin
                op = sample_op(3'($urandom_range(0, 1)), hot_pos[pick][0],
                               hot_pos[pick][1], hot_pos[pick][2]);
                locate_bin(op, bx, by, bz);
                op = read_op(op.component, bx[4:0], by[4:0], bz[4:0]);
            end else begin
                op = read_op(3'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
            end
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = sample_op(3'($urandom_range(0, 1)), hot_pos[pick][0],
                                           hot_pos[pick][1], hot_pos[pick][2]);
                4, 5:       op = sample_op(3'($urandom), $urandom, $urandom, $urandom);
                default:    op = sample_op(3'($urandom), near_cell(span), near_cell(span),
                                           near_cell(span));
            endcase
        end
        return op;
    endfunction

    // ---------------------------------------------------------------------
    // Input driver. A new item goes on the channel whenever the previous one
    // has been transferred (or none is up), after an optional idle burst.
    // The expected report is worked out at the edge of the transfer.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                due_reports.push_back(histogram_step(on_bus));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (op_queue.size() != 0) begin
                    on_bus = op_queue.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.action    <= on_bus.action;
                    in_ch.component <= on_bus.component;
                    in_ch.pos_x     <= on_bus.pos_x;
                    in_ch.pos_y     <= on_bus.pos_y;
                    in_ch.pos_z     <= on_bus.pos_z;
                    in_ch.read_x    <= on_bus.read_x;
                    in_ch.read_y    <= on_bus.read_y;
                    in_ch.read_z    <= on_bus.read_z;
                    // The burst, if any, follows this item's transfer.
                    if (idle_on && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 5);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // A long hold-off of the receiver, counted here so that it runs on its
    // own while the driver keeps offering items and the block backs up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fault_count++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Result monitor. Every transfer on the result channel is matched with
    // the oldest pending report, field by field. Ready drops in short random
    // bursts and for the whole of a hold-off.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bin_report want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_reports.size() == 0) begin
                    $error("result transfer with no pending expectation");
                    fault_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("bin_x", 32'(want.bin_x), 32'(out_ch.bin_x));
                    check_field("bin_y", 32'(want.bin_y), 32'(out_ch.bin_y));
                    check_field("bin_z", 32'(want.bin_z), 32'(out_ch.bin_z));
                    check_field("bin_count", want.bin_count, out_ch.bin_count);
                    check_field("component_max", want.component_max, out_ch.component_max);
                end
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
                out_ch.ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Configuration writes go out on consecutive edges; the local copy is
    // updated at once since nothing is in flight while they happen.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        if (idx <= CFG_INV_ZZ) inv_cell[idx] = value;
    endtask

    // Loads all six inverse entries, then pokes both unused indexes with
    // junk that must leave the matrix alone.
    task automatic load_cell(input logic [31:0] xx, input logic [31:0] xy,
                             input logic [31:0] xz, input logic [31:0] yy,
                             input logic [31:0] yz, input logic [31:0] zz);
        write_reg(CFG_INV_XX, xx);
        write_reg(CFG_INV_XY, xy);
        write_reg(CFG_INV_XZ, xz);
        write_reg(CFG_INV_YY, yy);
        write_reg(CFG_INV_YZ, yz);
        write_reg(CFG_INV_ZZ, zz);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Inverse of a cell edge of the given length, in units of 2^-32.
    function automatic logic [31:0] inv_len(input int unsigned len);
        return 32'((64'd1 << 32) / len);
    endfunction

    // A box of random edges with small random shear, and fresh hot spots.
    // Returns the half-width of the sampling window in Q16.16.
    task automatic load_random_box(input int unsigned lo, input int unsigned hi,
                                   output int unsigned span);
        int unsigned lx;
        int unsigned ly;
        int unsigned lz;
        lx = $urandom_range(lo, hi);
        ly = $urandom_range(lo, hi);
        lz = $urandom_range(lo, hi);
        load_cell(inv_len(lx), near_cell(inv_len(lx) / 8), near_cell(inv_len(lx) / 8),
                  inv_len(ly), near_cell(inv_len(ly) / 8), inv_len(lz));
        span = 3 * hi * 65536;
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) hot_pos[i][k] = near_cell(span);
        end
    endtask

    // The driver and monitor go quiet: nothing queued, nothing on the
    // channel, every report in. The check is made between clock edges so
    // that a pop and the valid it raises are seen together. A settling wait
    // then covers the pipeline.
    task automatic wait_drained();
        while (op_queue.size() != 0 || in_ch.valid || due_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned span);
        for (int unsigned n = 0; n < count; n++) op_queue.push_back(random_op(span));
    endtask

    // Generous bound, since the reset sweep alone has to clear the whole store.
    initial begin
        #9_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus sequence.
    // ---------------------------------------------------------------------
    initial begin
        int unsigned span;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_SAMPLE;
        in_ch.component = '0;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        in_ch.pos_z     = '0;
        in_ch.read_x    = '0;
        in_ch.read_y    = '0;
        in_ch.read_z    = '0;
        out_ch.ready    = 1'b0;
        for (int i = 0; i < 6; i++) inv_cell[i] = '0;
        for (int c = 0; c < COMPONENTS; c++) peak_count[c] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An orthorhombic-ish cell of 20 x 25 x 30 with some
        // shear. The origin lands in bin zero, twice, so its count is two.
        // The largest and smallest positions and a small negative one must
        // wrap into the unit cell rather than fall outside the grid.
        idle_on  <= 1'b1;
        stall_on <= 1'b1;
        load_cell(inv_len(20), 32'hF000_0000, 32'h0800_0000, inv_len(25),
                  32'hF800_0000, inv_len(30));
        op_queue.push_back(sample_op(3'd0, 32'd0, 32'd0, 32'd0));
        op_queue.push_back(sample_op(3'd0, 32'd0, 32'd0, 32'd0));
        op_queue.push_back(sample_op(3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        op_queue.push_back(sample_op(3'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        op_queue.push_back(sample_op(3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        op_queue.push_back(sample_op(3'd2, 32'h0013_FFFF, 32'h0018_FFFF, 32'h001D_FFFF));
        op_queue.push_back(read_op(3'd0, 5'd0, 5'd0, 5'd0));
        op_queue.push_back(read_op(3'd7, 5'd31, 5'd31, 5'd31));
        op_queue.push_back(read_op(3'd5, 5'd0, 5'd31, 5'd0));
        op_queue.push_back(read_op(3'd4, 5'd31, 5'd0, 5'd31));
        wait_drained();

        // Largest positive entries everywhere.
        load_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        op_queue.push_back(sample_op(3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        op_queue.push_back(sample_op(3'd6, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        op_queue.push_back(sample_op(3'd6, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001));
        op_queue.push_back(read_op(3'd6, 5'd31, 5'd31, 5'd31));
        wait_drained();

        // Most negative entries everywhere.
        load_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
        op_queue.push_back(sample_op(3'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        op_queue.push_back(sample_op(3'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        op_queue.push_back(sample_op(3'd5, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
        wait_drained();

        // A zero matrix sends everything to bin zero, so counts and the
        // component maximum climb together.
        load_cell(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        op_queue.push_back(sample_op(3'd4, $urandom, $urandom, $urandom));
        op_queue.push_back(sample_op(3'd4, $urandom, $urandom, $urandom));
        op_queue.push_back(sample_op(3'd4, $urandom, $urandom, $urandom));
        op_queue.push_back(read_op(3'd4, 5'd0, 5'd0, 5'd0));
        wait_drained();

        // Random part, first phase: a realistic cell, with one long
        // receiver hold-off while the sender keeps going.
        load_random_box(4, 40, span);
        run_random(150, span);
        hold_req <= hold_req + 1;
        wait_drained();

        // Fully random matrix entries.
        load_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_random(150, span);
        wait_drained();

        // Zero matrix again: a heavy pile-up on bin zero.
        load_cell(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_random(100, span);
        wait_drained();

        // Tiny cell: few distinct bins per unit, many repeat hits.
        load_random_box(2, 6, span);
        run_random(150, span);
        wait_drained();

        // Last stretch runs at full rate on both sides.
        idle_on  <= 1'b0;
        stall_on <= 1'b0;
        load_random_box(4, 40, span);
        run_random(180, span);
        wait_drained();

        if (fault_count == 0 && due_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
